[src/gqvg_pkg.sv]
// Package for the glyph quad vertex generator.
// Holds the item and vertex types, function codes, sizes and the saturation helper.
// Depends on nothing; every module of the block imports it.
package gqvg_pkg;

	localparam int GLYPH_COUNT = 128;
	localparam int CODE_COUNT  = 256;
	localparam int GLY_AW      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int MAP_AW      = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

	localparam int QDEPTH      = 4;
	localparam int QAW         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW         = $clog2(QDEPTH + 1);
	localparam int PIPE_STAGES = 4;
	localparam int CRD_W       = $clog2(QDEPTH + PIPE_STAGES + 1);

	localparam logic [1:0] FN_MAP   = 2'd0;
	localparam logic [1:0] FN_GLYPH = 2'd1;
	localparam logic [1:0] FN_START = 2'd2;
	localparam logic [1:0] FN_DRAW  = 2'd3;

	localparam logic [2:0] VTX_LT    = 3'd0;
	localparam logic [2:0] VTX_RT    = 3'd1;
	localparam logic [2:0] VTX_LB    = 3'd2;
	localparam logic [2:0] VTX_RB    = 3'd3;
	localparam logic [2:0] VTX_LB2   = 3'd4;
	localparam logic [2:0] VTX_LAST  = 3'd5;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         code_point;
		logic [6:0]         glyph_index;
		logic [11:0]        atlas_x;
		logic [11:0]        atlas_y;
		logic [7:0]         glyph_width;
		logic [7:0]         glyph_height;
		logic signed [7:0]  origin_x;
		logic signed [7:0]  origin_y;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic [23:0]        scale;
	} item_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic [12:0]        tex_u;
		logic [12:0]        tex_v;
		logic               last;
	} vert_t;

	typedef struct packed {
		logic [11:0]       ax;
		logic [11:0]       ay;
		logic [7:0]        w;
		logic [7:0]        h;
		logic signed [7:0] ox;
		logic signed [7:0] oy;
	} glyph_t;

	typedef struct packed {
		logic signed [33:0] l;
		logic signed [33:0] t;
		logic [31:0]        sw;
		logic [31:0]        sh;
		logic [12:0]        u0;
		logic [12:0]        u1;
		logic [12:0]        v0;
		logic [12:0]        v1;
	} quad_t;

	typedef struct packed {
		logic             empty;
		logic [QCW-1:0]   count;
	} qstat_t;

	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
			r = v[31:0];
		end else if (v[35]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

[src/gqvg_front.sv]
// Front part: accepts items, keeps the glyph map, glyph metrics and pen state.
// Draw items run through four stages that end in quad corner values for the queue.
// Depends on gqvg_pkg.
module gqvg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  gqvg_pkg::item_t item,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data,
	input  gqvg_pkg::qstat_t qstat,
	output logic            q_push,
	output gqvg_pkg::quad_t q_data
);
	import gqvg_pkg::*;

	logic                  acc;
	logic                  is_draw;
	logic [MAP_AW-1:0]     map_addr;
	logic [GLY_AW-1:0]     gly_waddr;
	logic [CRD_W-1:0]      crd_sum;
	logic [31:0]           adv_prod;
	logic signed [35:0]    pen_next;
	logic [GLY_AW-1:0]     gly_raddr;

	logic [7:0]            pen_adv_q;
	logic signed [31:0]    pen_x_q;
	logic signed [31:0]    pen_y_q;
	logic [23:0]           scale_q;
	logic [CODE_COUNT-1:0] map_vld_q;
	logic [6:0]            map_mem [CODE_COUNT];
	glyph_t                gly_mem [GLYPH_COUNT];

	logic                  gw_vld_s1;
	logic [GLY_AW-1:0]     gw_addr_s1;
	glyph_t                gw_data_s1;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [6:0]            idx_s1;
	logic                  hit_s1;
	logic signed [31:0]    px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic [23:0]           sc_s1, sc_s2;
	glyph_t                gly_s2;
	logic signed [32:0]    sox_s3, soy_s3;
	logic [31:0]           sw_s3, sh_s3;
	logic [12:0]           u0_s3, u1_s3, v0_s3, v1_s3;
	quad_t                 quad_s4;

	assign crd_sum = CRD_W'(qstat.count) + CRD_W'(v_s1) + CRD_W'(v_s2)
		+ CRD_W'(v_s3) + CRD_W'(v_s4);
	assign full     = (crd_sum >= CRD_W'(QDEPTH));
	assign acc      = push && !full;
	assign is_draw  = (item.func == FN_DRAW);
	assign map_addr = MAP_AW'(item.code_point);
	assign gly_waddr = GLY_AW'(item.glyph_index);
	assign adv_prod = {8'b0, scale_q} * {24'b0, pen_adv_q};
	assign pen_next = $signed({{4{pen_x_q[31]}}, pen_x_q}) + $signed({4'b0, adv_prod});
	assign gly_raddr = (hit_s1 && int'(idx_s1) < GLYPH_COUNT) ? GLY_AW'(idx_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_adv_q <= '0;
			pen_x_q   <= '0;
			pen_y_q   <= '0;
			scale_q   <= '0;
			map_vld_q <= '0;
			gw_vld_s1 <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pen_adv_q <= cfg_wr_data;
			end
			if (acc) begin
				case (item.func)
					FN_MAP: begin
						if (int'(item.code_point) < CODE_COUNT
							&& int'(item.glyph_index) < GLYPH_COUNT) begin
							map_vld_q[map_addr] <= 1'b1;
						end
					end
					FN_START: begin
						pen_x_q <= item.start_x;
						pen_y_q <= item.start_y;
						scale_q <= item.scale;
					end
					FN_DRAW: begin
						pen_x_q <= sat36(pen_next);
					end
					default: begin
					end
				endcase
			end
			gw_vld_s1 <= acc && item.func == FN_GLYPH
				&& int'(item.glyph_index) < GLYPH_COUNT;
			v_s1 <= acc && is_draw;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && item.func == FN_MAP && int'(item.code_point) < CODE_COUNT
			&& int'(item.glyph_index) < GLYPH_COUNT) begin
			map_mem[map_addr] <= item.glyph_index;
		end
		gw_addr_s1 <= gly_waddr;
		gw_data_s1 <= '{ax: item.atlas_x, ay: item.atlas_y,
			w: item.glyph_width, h: item.glyph_height,
			ox: item.origin_x, oy: item.origin_y};
		if (gw_vld_s1) begin
			gly_mem[gw_addr_s1] <= gw_data_s1;
		end
		idx_s1 <= map_mem[map_addr];
		hit_s1 <= (int'(item.code_point) < CODE_COUNT) && map_vld_q[map_addr];
		px_s1  <= pen_x_q;
		py_s1  <= pen_y_q;
		sc_s1  <= scale_q;

		gly_s2 <= gly_mem[gly_raddr];
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		sc_s2  <= sc_s1;

		sox_s3 <= $signed({9'b0, sc_s2}) * 33'(gly_s2.ox);
		soy_s3 <= $signed({9'b0, sc_s2}) * 33'(gly_s2.oy);
		sw_s3  <= {8'b0, sc_s2} * {24'b0, gly_s2.w};
		sh_s3  <= {8'b0, sc_s2} * {24'b0, gly_s2.h};
		u0_s3  <= {1'b0, gly_s2.ax};
		u1_s3  <= {1'b0, gly_s2.ax} + {5'b0, gly_s2.w};
		v0_s3  <= {1'b0, gly_s2.ay};
		v1_s3  <= {1'b0, gly_s2.ay} + {5'b0, gly_s2.h};
		px_s3  <= px_s2;
		py_s3  <= py_s2;

		quad_s4.l  <= $signed({{2{px_s3[31]}}, px_s3}) - $signed({sox_s3[32], sox_s3});
		quad_s4.t  <= $signed({{2{py_s3[31]}}, py_s3}) - $signed({soy_s3[32], soy_s3});
		quad_s4.sw <= sw_s3;
		quad_s4.sh <= sh_s3;
		quad_s4.u0 <= u0_s3;
		quad_s4.u1 <= u1_s3;
		quad_s4.v0 <= v0_s3;
		quad_s4.v1 <= v1_s3;
	end

	assign q_push = v_s4;
	assign q_data = quad_s4;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		crd_sum <= CRD_W'(QDEPTH))
		else $error("Items in flight exceed the queue space.");

endmodule

[src/gqvg_queue.sv]
// Short queue of quad corner values between the front and back parts.
// Depends on gqvg_pkg.
module gqvg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_push,
	input  gqvg_pkg::quad_t  q_data,
	input  logic             q_pop,
	output gqvg_pkg::quad_t  q_head,
	output gqvg_pkg::qstat_t qstat
);
	import gqvg_pkg::*;

	quad_t          q_mem [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;

	assign q_head      = q_mem[rp_q];
	assign qstat.count = cnt_q;
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !q_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem[wp_q] <= q_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (cnt_q < QCW'(QDEPTH) || q_pop))
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0)
		else $error("Queue read while empty.");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("Queue count did not follow a write.");

endmodule

[src/gqvg_back.sv]
// Back part: saturates the quad corners and sends out six vertices per character.
// Holds one character in expansion and one vertex in the output register.
// Depends on gqvg_pkg.
module gqvg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  gqvg_pkg::quad_t  q_head,
	input  gqvg_pkg::qstat_t qstat,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output gqvg_pkg::vert_t  result
);
	import gqvg_pkg::*;

	logic               out_load;
	logic               cur_free;
	logic               right;
	logic               bottom;
	logic signed [35:0] l_ext, t_ext, r_ext, b_ext;

	logic               cur_vld_q;
	logic [2:0]         cnt_q;
	logic signed [31:0] xl_q, xr_q, yt_q, yb_q;
	logic [12:0]        u0_q, u1_q, v0_q, v1_q;
	logic               out_vld_q;
	vert_t              out_q;

	assign out_load = !out_vld_q || pop;
	assign cur_free = !cur_vld_q || (out_load && cnt_q == VTX_LAST);
	assign q_pop    = cur_free && !qstat.empty;
	assign empty    = !out_vld_q;
	assign result   = out_q;

	assign l_ext = $signed({{2{q_head.l[33]}}, q_head.l});
	assign t_ext = $signed({{2{q_head.t[33]}}, q_head.t});
	assign r_ext = l_ext + $signed({4'b0, q_head.sw});
	assign b_ext = t_ext + $signed({4'b0, q_head.sh});

	always_comb begin
		right  = 1'b0;
		bottom = 1'b0;
		case (cnt_q)
			VTX_LT: begin
			end
			VTX_RT: begin
				right = 1'b1;
			end
			VTX_LB, VTX_LB2: begin
				bottom = 1'b1;
			end
			VTX_RB: begin
				right  = 1'b1;
				bottom = 1'b1;
			end
			VTX_LAST: begin
				right = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= cur_vld_q;
			end
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				cnt_q     <= '0;
			end else if (out_load && cur_vld_q) begin
				if (cnt_q == VTX_LAST) begin
					cur_vld_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			xl_q <= sat36(l_ext);
			xr_q <= sat36(r_ext);
			yt_q <= sat36(t_ext);
			yb_q <= sat36(b_ext);
			u0_q <= q_head.u0;
			u1_q <= q_head.u1;
			v0_q <= q_head.v0;
			v1_q <= q_head.v1;
		end
		if (out_load && cur_vld_q) begin
			out_q.vertex_x <= right ? xr_q : xl_q;
			out_q.vertex_y <= bottom ? yb_q : yt_q;
			out_q.tex_u    <= right ? u1_q : u0_q;
			out_q.tex_v    <= bottom ? v1_q : v0_q;
			out_q.last     <= (cnt_q == VTX_LAST);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> cnt_q <= VTX_LAST)
		else $error("Vertex count beyond the last vertex.");

	a_last_ends_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cur_vld_q && cnt_q == VTX_LAST && !q_pop) |=> !cur_vld_q)
		else $error("Character kept after its last vertex.");

endmodule

[src/glyph_quad_vertex_generator_core.sv]
// Top level of the glyph quad vertex generator: front, queue and back.
// Depends on gqvg_pkg, gqvg_front, gqvg_queue and gqvg_back.
//
// Channel   Handshake           Payload          Direction
// input     push / full         item (item_t)    in
// result    empty / pop         result (vert_t)  out
// config    cfg_wr_en           cfg_wr_data      in
//
// An item is taken in every cycle while full is low; a draw item gives six vertices,
// one per cycle while pop is held high, so the output port sets the character rate.
// A draw item reaches the queue through the map read, the metrics read, the scale
// multipliers and the corner adders, in that order, each one registered.
// Full rises when the queue and the four front stages together hold four draw items.
// Reset clears the glyph map, the pen, the scale, the advance and all valid flags.
module glyph_quad_vertex_generator_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  gqvg_pkg::item_t item,
	output logic            empty,
	input  logic            pop,
	output gqvg_pkg::vert_t result,
	input  logic            cfg_wr_en,
	input  logic [7:0]      cfg_wr_data
);
	import gqvg_pkg::*;

	logic   q_push;
	logic   q_pop;
	quad_t  q_data;
	quad_t  q_head;
	qstat_t qstat;

	gqvg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.qstat       (qstat),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	gqvg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_data (q_data),
		.q_pop  (q_pop),
		.q_head (q_head),
		.qstat  (qstat)
	);

	gqvg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (q_head),
		.qstat  (qstat),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for glyph_quad_vertex_generator_core: directed items, then random phases.
// Each vertex is checked against an in-bench model of the glyph map, metrics and pen,
// or against a typed value for the first vertex of some directed draws. Depends on gqvg_pkg and the RTL of the block.
module tb;
	import gqvg_pkg::*;

	typedef struct {
		bit          is_cfg;
		logic [7:0]  adv;
		item_t       it;
		bit          typed;
		vert_t       first;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	item_t       item = '0;
	logic        empty;
	logic        pop = 1'b0;
	vert_t       result;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	logic [6:0]         glyph_map [0:CODE_COUNT-1];
	glyph_t             glyph_tab [0:GLYPH_COUNT-1];
	bit                 glyph_seen [0:GLYPH_COUNT-1];
	logic signed [31:0] pen_x = '0;
	logic signed [31:0] pen_y = '0;
	logic [23:0]        text_scale = '0;
	logic [7:0]         pen_adv = '0;

	vert_t pending_verts [$];
	row_t  script [$];
	int    mismatches = 0;
	bit    calm = 1'b0;

	glyph_quad_vertex_generator_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit stall_now();
		return !calm && ($urandom_range(0, 99) < 12);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic item_t noise();
		logic [191:0] raw;
		item_t it;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		return it;
	endfunction

	function automatic int trace_item(input item_t it, output vert_t quad [6]);
		glyph_t g;
		longint s, l, r, t, b;
		logic [12:0] u0, u1, v0, v1;
		int idx;
		case (it.func)
			FN_MAP: begin
				if (int'(it.glyph_index) < GLYPH_COUNT) glyph_map[it.code_point] = it.glyph_index;
				return 0;
			end
			FN_GLYPH: begin
				if (int'(it.glyph_index) < GLYPH_COUNT) begin
					glyph_tab[it.glyph_index] = '{it.atlas_x, it.atlas_y, it.glyph_width,
						it.glyph_height, it.origin_x, it.origin_y};
					glyph_seen[it.glyph_index] = 1'b1;
				end
				return 0;
			end
			FN_START: begin
				pen_x = it.start_x;
				pen_y = it.start_y;
				text_scale = it.scale;
				return 0;
			end
			default: begin
				idx = int'(glyph_map[it.code_point]);
				if (idx >= GLYPH_COUNT) idx = 0;
				g = glyph_tab[idx];
				s = longint'(text_scale);
				l = longint'(pen_x) - s * longint'($signed(g.ox));
				t = longint'(pen_y) - s * longint'($signed(g.oy));
				r = l + s * longint'(g.w);
				b = t + s * longint'(g.h);
				u0 = 13'(g.ax);
				u1 = 13'(g.ax) + 13'(g.w);
				v0 = 13'(g.ay);
				v1 = 13'(g.ay) + 13'(g.h);
				quad[0] = '{clamp32(l), clamp32(t), u0, v0, 1'b0};
				quad[1] = '{clamp32(r), clamp32(t), u1, v0, 1'b0};
				quad[2] = '{clamp32(l), clamp32(b), u0, v1, 1'b0};
				quad[3] = '{clamp32(r), clamp32(b), u1, v1, 1'b0};
				quad[4] = '{clamp32(l), clamp32(b), u0, v1, 1'b0};
				quad[5] = '{clamp32(r), clamp32(t), u1, v0, 1'b1};
				pen_x = clamp32(longint'(pen_x) + s * longint'(pen_adv));
				return 6;
			end
		endcase
	endfunction

	// Draws only of characters whose glyph has been loaded; otherwise load that glyph.
	function automatic item_t next_item();
		item_t it;
		int pick;
		it = noise();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if (glyph_seen[glyph_map[it.code_point]]) begin
				it.func = FN_DRAW;
			end else begin
				it.func = FN_GLYPH;
				it.glyph_index = glyph_map[it.code_point];
			end
		end else if (pick < 60) begin
			it.func = FN_GLYPH;
		end else if (pick < 78) begin
			it.func = FN_MAP;
		end else begin
			it.func = FN_START;
			case ($urandom_range(0, 9))
				0: ;
				1: it.scale = 24'hFF_FFFF;
				default: it.scale = 24'($urandom_range(0, 24'h03_FFFF));
			endcase
			if ($urandom_range(0, 9) < 7) begin
				it.start_x = 32'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
				it.start_y = 32'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
			end
		end
		return it;
	endfunction

	function automatic row_t row_cfg(input logic [7:0] v);
		row_t rw;
		rw = '{1'b1, v, noise(), 1'b0, '0};
		return rw;
	endfunction

	function automatic row_t row_map(input logic [7:0] cp, input logic [6:0] gi);
		row_t rw;
		rw = '{1'b0, '0, noise(), 1'b0, '0};
		rw.it.func = FN_MAP;
		rw.it.code_point = cp;
		rw.it.glyph_index = gi;
		return rw;
	endfunction

	function automatic row_t row_glyph(input logic [6:0] gi, input logic [11:0] ax,
		input logic [11:0] ay, input logic [7:0] w, input logic [7:0] h,
		input logic signed [7:0] ox, input logic signed [7:0] oy);
		row_t rw;
		rw = '{1'b0, '0, noise(), 1'b0, '0};
		rw.it.func = FN_GLYPH;
		rw.it.glyph_index = gi;
		rw.it.atlas_x = ax;
		rw.it.atlas_y = ay;
		rw.it.glyph_width = w;
		rw.it.glyph_height = h;
		rw.it.origin_x = ox;
		rw.it.origin_y = oy;
		return rw;
	endfunction

	function automatic row_t row_start(input logic [31:0] x, input logic [31:0] y,
		input logic [23:0] sc);
		row_t rw;
		rw = '{1'b0, '0, noise(), 1'b0, '0};
		rw.it.func = FN_START;
		rw.it.start_x = x;
		rw.it.start_y = y;
		rw.it.scale = sc;
		return rw;
	endfunction

	function automatic row_t row_draw(input logic [7:0] cp, input bit typed, input vert_t v);
		row_t rw;
		rw = '{1'b0, '0, noise(), typed, v};
		rw.it.func = FN_DRAW;
		rw.it.code_point = cp;
		return rw;
	endfunction

	task automatic flag(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send(input item_t it, input bit typed, input vert_t first);
		vert_t quad [6];
		int n;
		@(negedge clk);
		while (stall_now()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		n = trace_item(it, quad);
		if (typed && n > 0) quad[0] = first;
		for (int k = 0; k < n; k++) pending_verts.push_back(quad[k]);
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_verts.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_advance(input logic [7:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pen_adv = v;
	endtask

	always @(negedge clk) begin
		pop <= !stall_now();
	end

	always @(posedge clk) begin
		vert_t want;
		if (arst_n && pop && !empty) begin
			if (pending_verts.size() == 0) begin
				flag($sformatf("vertex with none expected: %p", result));
			end else begin
				want = pending_verts.pop_front();
				if (result.vertex_x !== want.vertex_x)
					flag($sformatf("vertex_x %h, expected %h", result.vertex_x, want.vertex_x));
				if (result.vertex_y !== want.vertex_y)
					flag($sformatf("vertex_y %h, expected %h", result.vertex_y, want.vertex_y));
				if (result.tex_u !== want.tex_u)
					flag($sformatf("tex_u %0d, expected %0d", result.tex_u, want.tex_u));
				if (result.tex_v !== want.tex_v)
					flag($sformatf("tex_v %0d, expected %0d", result.tex_v, want.tex_v));
				if (result.last !== want.last)
					flag($sformatf("last %b, expected %b", result.last, want.last));
			end
		end
	end

	initial begin
		logic [7:0] adv;
		for (int i = 0; i < CODE_COUNT; i++) glyph_map[i] = '0;
		for (int i = 0; i < GLYPH_COUNT; i++) begin
			glyph_tab[i] = '0;
			glyph_seen[i] = 1'b0;
		end

		script.push_back(row_cfg(8'd0));
		script.push_back(row_glyph(7'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'sd0, 8'sd0));
		script.push_back(row_draw(8'd0, 1'b1, '{32'sd0, 32'sd0, 13'd0, 13'd0, 1'b0}));
		script.push_back(row_glyph(7'd127, 12'd4095, 12'd4095, 8'd255, 8'd255, -8'sd128,
			-8'sd128));
		script.push_back(row_map(8'd255, 7'd127));
		script.push_back(row_start(32'h7FFF_0000, 32'h7FFF_0000, 24'hFF_FFFF));
		script.push_back(row_draw(8'd255, 1'b1,
			'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 13'd4095, 13'd4095, 1'b0}));
		script.push_back(row_glyph(7'd1, 12'd0, 12'd0, 8'd255, 8'd255, 8'sd127, 8'sd127));
		script.push_back(row_map(8'd65, 7'd1));
		script.push_back(row_start(32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
		script.push_back(row_draw(8'd65, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 13'd0, 13'd0, 1'b0}));
		script.push_back(row_map(8'd200, 7'd5));
		script.push_back(row_glyph(7'd5, 12'd100, 12'd200, 8'd12, 8'd16, -8'sd3, 8'sd14));
		script.push_back(row_start(32'h0001_0000, 32'h0002_0000, 24'h01_0000));
		script.push_back(row_cfg(8'd255));
		script.push_back(row_draw(8'd65, 1'b0, '0));
		script.push_back(row_draw(8'd200, 1'b0, '0));
		script.push_back(row_draw(8'd65, 1'b0, '0));
		script.push_back(row_start(32'h7FFF_0000, 32'h0000_0000, 24'hFF_FFFF));
		script.push_back(row_draw(8'd200, 1'b0, '0));
		script.push_back(row_draw(8'd200, 1'b0, '0));
		script.push_back(row_map(8'd0, 7'd127));
		script.push_back(row_draw(8'd0, 1'b0, '0));
		script.push_back(row_cfg(8'd17));
		script.push_back(row_start(32'hFFFF_0000, 32'h0001_0000, 24'h00_8000));
		script.push_back(row_draw(8'd200, 1'b0, '0));
		script.push_back(row_draw(8'd255, 1'b0, '0));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				set_advance(script[i].adv);
			end else begin
				send(script[i].it, script[i].typed, script[i].first);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			adv = (ph == 3) ? 8'd255 : (ph == 4) ? 8'd0 : 8'($urandom_range(0, 255));
			set_advance(adv);
			calm = (ph == 2);
			repeat (72) send(next_item(), 1'b0, '0);
			calm = 1'b0;
		end
		settle();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

[sim.f]
src/gqvg_pkg.sv
src/gqvg_front.sv
src/gqvg_queue.sv
src/gqvg_back.sv
src/glyph_quad_vertex_generator_core.sv
sim/tb.sv
